FILE: src/hpa_pkg.sv
// Shared types and constants for the handle pool allocator.
package hpa_pkg;

   localparam int HANDLES_DEFAULT = 256;

   localparam int HANDLE_W = 8;
   localparam int CODE_W   = 2;

   typedef enum logic [CODE_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_TRY     = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   typedef enum logic [CODE_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD       = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

FILE: src/handle_pool_allocator_core.sv
// Handle pool allocator: free-list queue plus fresh counter, bitmap-checked release.
//
// Requests arrive on the req_ stream: tuser carries the action (allocate,
// try-allocate, release), tdata the handle to release. Each request gives
// exactly one response on the rsp_ stream: tdata is the granted handle
// (zero when nothing is granted), tuser the status code.
// A request is read from the free queue and allocated-bitmap RAMs in its
// accept cycle and modified and written back in the next cycle; the
// response is valid in the cycle after that. One request is in flight at a
// time: no new request is taken until the last one is written back, as
// the RAMs are read through a register ahead of the write-back.
// The response sits in an output register: while the receiver stalls, one
// result is held and req_tready drops until that result is taken. A result
// taken in the same cycle lets the next request in.
// Reset (synchronous, active high) clears the queue pointers and counters
// and then runs a clearing pass over the allocated bitmap, one entry per
// cycle, over all HANDLES entries; req_tready stays low until it is done.
module handle_pool_allocator_core #(
   parameter int HANDLES = hpa_pkg::HANDLES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [hpa_pkg::HANDLE_W-1:0] req_tdata,   // [7:0] handle
   input  logic [hpa_pkg::CODE_W-1:0]   req_tuser,   // [1:0] action
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [hpa_pkg::HANDLE_W-1:0] rsp_tdata,   // [7:0] granted_handle
   output logic [hpa_pkg::CODE_W-1:0]   rsp_tuser    // [1:0] status
);

   localparam int IDX_W = $clog2(HANDLES);
   localparam int CNT_W = $clog2(HANDLES + 1);
   localparam int HW    = hpa_pkg::HANDLE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HANDLES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HANDLES);

   hpa_pkg::state_type  state_ff, state_in;
   hpa_pkg::action_type action_ff, action_in;
   logic [HW-1:0]       handle_ff, handle_in;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [IDX_W-1:0] clear_idx_ff, clear_idx_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0]   rsp_data_ff, rsp_data_in;
   logic [hpa_pkg::CODE_W-1:0] rsp_user_ff, rsp_user_in;

   logic             fq_wr_en;
   logic [IDX_W-1:0] fq_rdata;
   logic             map_wr_en;
   logic [IDX_W-1:0] map_wr_addr;
   logic             map_wr_data;
   logic [IDX_W-1:0] map_rd_addr;
   logic             map_rdata;

   logic [IDX_W+HW-1:0] req_handle_ext;
   logic [IDX_W+HW-1:0] held_handle_ext;
   logic [IDX_W+HW-1:0] grant_ext;
   logic [IDX_W-1:0]    req_idx;
   logic [IDX_W-1:0]    held_idx;
   logic [IDX_W-1:0]    grant_idx;
   logic                handle_in_pool;
   logic                req_fire;

   // Map the fixed 8-bit handle field onto the pool index width and back.
   assign req_handle_ext  = {{IDX_W{1'b0}}, req_tdata};
   assign held_handle_ext = {{IDX_W{1'b0}}, handle_ff};
   assign req_idx         = req_handle_ext[IDX_W-1:0];
   assign held_idx        = held_handle_ext[IDX_W-1:0];
   assign grant_ext       = {{HW{1'b0}}, grant_idx};
   assign handle_in_pool  = ({{24{1'b0}}, handle_ff} < 32'(HANDLES));

   assign req_fire   = req_tvalid && req_tready;
   assign map_rd_addr = req_idx;

   hpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (HANDLES)
   ) u_free_queue (
      .clock   (clock),
      .wr_en   (fq_wr_en),
      .wr_addr (tail_ff),
      .wr_data (held_idx),
      .rd_addr (head_ff),
      .rd_data (fq_rdata)
   );

   hpa_ram #(
      .WIDTH (1),
      .DEPTH (HANDLES)
   ) u_alloc_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpa_pkg::S_CLEAR;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      handle_ff   <= handle_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      handle_in    = handle_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      clear_idx_in = clear_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      fq_wr_en     = 1'b0;
      map_wr_en    = 1'b0;
      map_wr_addr  = clear_idx_ff;
      map_wr_data  = 1'b0;
      grant_idx    = '0;

      unique case (state_ff)
         hpa_pkg::S_CLEAR: begin
            map_wr_en    = 1'b1;
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == LAST_IDX) begin
               state_in = hpa_pkg::S_IDLE;
            end
         end
         hpa_pkg::S_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               action_in = hpa_pkg::action_type'(req_tuser);
               handle_in = req_tdata;
               state_in  = hpa_pkg::S_EXEC;
            end
         end
         hpa_pkg::S_EXEC: begin
            state_in     = hpa_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_user_in  = hpa_pkg::ST_OK;
            unique case (action_ff)
               hpa_pkg::ACT_ALLOC, hpa_pkg::ACT_TRY: begin
                  priority if (count_ff != '0) begin
                     grant_idx   = fq_rdata;
                     head_in     = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                     count_in    = count_ff - 1'b1;
                     map_wr_en   = 1'b1;
                     map_wr_addr = grant_idx;
                     map_wr_data = 1'b1;
                     rsp_data_in = grant_ext[HW-1:0];
                  end else if (action_ff == hpa_pkg::ACT_TRY) begin
                     rsp_user_in = hpa_pkg::ST_EMPTY;
                  end else if (fresh_ff < FULL_CNT) begin
                     grant_idx   = fresh_ff[IDX_W-1:0];
                     fresh_in    = fresh_ff + 1'b1;
                     map_wr_en   = 1'b1;
                     map_wr_addr = grant_idx;
                     map_wr_data = 1'b1;
                     rsp_data_in = grant_ext[HW-1:0];
                  end else begin
                     rsp_user_in = hpa_pkg::ST_EXHAUSTED;
                  end
               end
               hpa_pkg::ACT_RELEASE: begin
                  priority if (!handle_in_pool || !map_rdata) begin
                     rsp_user_in = hpa_pkg::ST_BAD;
                  end else if (count_ff < FULL_CNT) begin
                     map_wr_en   = 1'b1;
                     map_wr_addr = held_idx;
                     map_wr_data = 1'b0;
                     fq_wr_en    = 1'b1;
                     tail_in     = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                     count_in    = count_ff + 1'b1;
                  end else begin
                     rsp_user_in = hpa_pkg::ST_OK;
                  end
               end
               default: begin
                  // unused action code: answer ok, change nothing
                  rsp_user_in = hpa_pkg::ST_OK;
               end
            endcase
         end
         default: begin
            state_in = hpa_pkg::S_CLEAR;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // queue occupancy and fresh counter stay within the pool
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("free queue count exceeds pool size");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= FULL_CNT)
      else $error("fresh counter exceeds pool size");

   // equal pointers mean an empty or a completely full queue
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) |-> (count_ff == '0 || count_ff == FULL_CNT))
      else $error("queue pointers disagree with count");

   // every accepted request produces a response, registered after the execute state
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ##1 rsp_valid_ff)
      else $error("accepted request produced no response");

   // no request taken while the bitmap is being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hpa_pkg::S_CLEAR) |-> !req_tready)
      else $error("request accepted during bitmap clear");

endmodule

FILE: src/hpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
